// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ----- src/i2cm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master write/read engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned WriteDepth = 256;
  localparam int unsigned WrAw       = $clog2(WriteDepth);
  localparam int unsigned CfgAw      = 4;
  localparam int unsigned CfgDw      = 32;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_START = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_IDLE   = 2'd0,
    STATUS_BUSY   = 2'd1,
    STATUS_FAILED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_WRITE_LENGTH = 2'd0,
    REG_READ_LENGTH  = 2'd1,
    REG_RESTART_POS  = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_FAILED   = 3'd1,
    ST_START    = 3'd2,
    ST_SEND     = 3'd3,
    ST_RECV     = 3'd4,
    ST_STOP     = 3'd5,
    ST_STOPFAIL = 3'd6
  } state_e;

  // Step within one bit/byte slot of the bus sequence.
  typedef enum logic [2:0] {
    PH_SETUP    = 3'd0,
    PH_RISE     = 3'd1,
    PH_HIGH     = 3'd2,
    PH_ACK_RISE = 3'd3,
    PH_ACK_HIGH = 3'd4,
    PH_RS_RISE  = 3'd5,
    PH_RS_HIGH  = 3'd6,
    PH_RS_FALL  = 3'd7
  } phase_e;

  typedef struct packed {
    logic [7:0] write_length;
    logic [7:0] read_length;
    logic [7:0] restart_position;
  } cfg_t;

  typedef struct packed {
    logic            we;
    logic [WrAw-1:0] addr;
    logic [7:0]      data;
  } mem_wr_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic [7:0] read_data;
    logic       read_valid;
    logic [1:0] status;
  } result_t;

endpackage

// ----- src/i2cm_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_chan_if
// Valid/ready channels for tick requests and bus results.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] write_byte;
  logic       sda_in;
  logic       scl_in;

  modport source (output valid, mode, write_byte, sda_in, scl_in, input ready);
  modport sink   (input valid, mode, write_byte, sda_in, scl_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic [7:0] read_data;
  logic       read_valid;
  logic [1:0] status;

  modport source (output valid, scl_out, sda_out, read_data, read_valid, status,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, read_data, read_valid, status,
                  output ready);
endinterface

// ----- src/i2cm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module i2cm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/i2cm_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_regs
// APB configuration registers: write length, read length, restart position.
// ----------------------------------------------------------------------------
module i2cm_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [i2cm_pkg::CfgAw-1:0] paddr,
  input  logic [i2cm_pkg::CfgDw-1:0] pwdata,
  output logic [i2cm_pkg::CfgDw-1:0] prdata,
  output logic                      pready,
  output i2cm_pkg::cfg_t            cfg_o
);
  import i2cm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WRITE_LENGTH: cfg_d.write_length     = pwdata[7:0];
        REG_READ_LENGTH:  cfg_d.read_length      = pwdata[7:0];
        REG_RESTART_POS:  cfg_d.restart_position = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WRITE_LENGTH: prdata = {{(CfgDw-8){1'b0}}, cfg_q.write_length};
      REG_READ_LENGTH:  prdata = {{(CfgDw-8){1'b0}}, cfg_q.read_length};
      REG_RESTART_POS:  prdata = {{(CfgDw-8){1'b0}}, cfg_q.restart_position};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.write_length     <= 8'd1;
      cfg_q.read_length      <= 8'd0;
      cfg_q.restart_position <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/i2cm_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: START, byte writes with ACK check, repeated START, reads,
// STOP. Fetches write bytes from the store, read ahead of the request that uses them.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [1:0]                 mode_i,
  input  logic [7:0]                 write_byte_i,
  input  logic                       sda_i,
  input  logic                       scl_i,
  input  i2cm_pkg::cfg_t             cfg_i,
  input  logic [7:0]                 mem_data_i,
  output logic [i2cm_pkg::WrAw-1:0]  rd_addr_o,
  output i2cm_pkg::mem_wr_t          wr_o,
  output i2cm_pkg::result_t          res_o
);
  import i2cm_pkg::*;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] widx_q, widx_d;
  logic [7:0] rcnt_q, rcnt_d;
  logic [7:0] shift_q, shift_d;
  logic       restart_q, restart_d;
  logic [7:0] lcnt_q, lcnt_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;

  logic       idle;
  logic       tick;
  logic [2:0] bit_m1;
  logic [7:0] shift_in;
  logic [7:0] rcnt_inc;
  logic       got_valid;

  assign idle     = (state_q == ST_IDLE) || (state_q == ST_FAILED);
  assign tick     = fire_i && (mode_i == MODE_TICK);
  assign bit_m1   = bit_q - 3'd1;
  assign shift_in = {shift_q[6:0], sda_i};
  assign rcnt_inc = rcnt_q + 8'd1;

  // Next state
  always_comb begin
    state_d = state_q;
    if (fire_i && mode_i == MODE_START && idle) begin
      state_d = ST_START;
    end else if (tick) begin
      unique case (state_q)
        ST_START: if (phase_q != PH_SETUP) state_d = ST_SEND;
        ST_SEND: begin
          if (phase_q == PH_ACK_HIGH && scl_i) begin
            if (sda_i) begin
              state_d = ST_STOPFAIL;
            end else if (widx_q == cfg_i.write_length) begin
              state_d = (cfg_i.read_length != 8'd0) ? ST_RECV : ST_STOP;
            end
          end
        end
        ST_RECV: begin
          if (phase_q == PH_ACK_HIGH && scl_i && rcnt_q == cfg_i.read_length) begin
            state_d = ST_STOP;
          end
        end
        ST_STOP: begin
          if (phase_q != PH_SETUP && phase_q != PH_RISE && scl_i) state_d = ST_IDLE;
        end
        ST_STOPFAIL: begin
          if (phase_q != PH_SETUP && phase_q != PH_RISE && scl_i) state_d = ST_FAILED;
        end
        default: ;
      endcase
    end
  end

  // Datapath and line drive
  always_comb begin
    phase_d   = phase_q;
    bit_d     = bit_q;
    widx_d    = widx_q;
    rcnt_d    = rcnt_q;
    shift_d   = shift_q;
    restart_d = restart_q;
    lcnt_d    = lcnt_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    got_valid = 1'b0;
    wr_o.we   = 1'b0;
    wr_o.addr = lcnt_q[WrAw-1:0];
    wr_o.data = write_byte_i;

    if (fire_i && mode_i == MODE_LOAD && idle) begin
      wr_o.we = 1'b1;
      lcnt_d  = lcnt_q + 8'd1;
    end else if (fire_i && mode_i == MODE_START && idle) begin
      phase_d   = PH_SETUP;
      widx_d    = 8'd0;
      rcnt_d    = 8'd0;
      lcnt_d    = 8'd0;
      restart_d = (cfg_i.restart_position != 8'd0);
    end else if (tick) begin
      unique case (state_q)
        ST_START: begin
          if (phase_q == PH_SETUP) begin
            // wait for a free bus
            if (sda_i && scl_i) begin
              sda_d   = 1'b0;
              phase_d = PH_RISE;
            end
          end else begin
            scl_d   = 1'b0;
            phase_d = PH_SETUP;
          end
        end
        ST_SEND: begin
          unique case (phase_q)
            PH_RISE: begin
              scl_d   = 1'b1;
              phase_d = PH_HIGH;
            end
            PH_HIGH: begin
              if (scl_i) begin
                scl_d = 1'b0;
                if (bit_q != 3'd0) begin
                  bit_d   = bit_m1;
                  sda_d   = shift_q[bit_m1];
                  phase_d = PH_RISE;
                end else begin
                  sda_d   = 1'b1;
                  widx_d  = widx_q + 8'd1;
                  phase_d = PH_ACK_RISE;
                end
              end
            end
            PH_ACK_RISE: begin
              scl_d   = 1'b1;
              phase_d = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
              if (scl_i) begin
                scl_d = 1'b0;
                sda_d = 1'b0;
                if (sda_i) begin
                  phase_d = PH_RISE;
                end else if (widx_q != cfg_i.write_length) begin
                  phase_d = PH_SETUP;
                end else if (cfg_i.read_length != 8'd0) begin
                  phase_d = PH_SETUP;
                end else begin
                  phase_d = PH_RISE;
                end
              end
            end
            PH_RS_RISE: begin
              scl_d   = 1'b1;
              phase_d = PH_RS_HIGH;
            end
            PH_RS_HIGH: begin
              if (scl_i) begin
                sda_d     = 1'b0;
                restart_d = 1'b0;
                phase_d   = PH_RS_FALL;
              end
            end
            PH_RS_FALL: begin
              scl_d   = 1'b0;
              phase_d = PH_SETUP;
            end
            default: begin
              if (restart_q && widx_q == cfg_i.restart_position) begin
                sda_d   = 1'b1;
                phase_d = PH_RS_RISE;
              end else begin
                shift_d = mem_data_i;
                bit_d   = 3'd7;
                sda_d   = mem_data_i[7];
                phase_d = PH_RISE;
              end
            end
          endcase
        end
        ST_RECV: begin
          unique case (phase_q)
            PH_RISE: begin
              scl_d   = 1'b1;
              phase_d = PH_HIGH;
            end
            PH_HIGH: begin
              if (scl_i) begin
                shift_d = shift_in;
                scl_d   = 1'b0;
                if (bit_q != 3'd0) begin
                  bit_d   = bit_m1;
                  phase_d = PH_RISE;
                end else begin
                  got_valid = 1'b1;
                  rcnt_d    = rcnt_inc;
                  // ACK all but the last byte
                  if (rcnt_inc != cfg_i.read_length) sda_d = 1'b0;
                  phase_d = PH_ACK_RISE;
                end
              end
            end
            PH_ACK_RISE: begin
              scl_d   = 1'b1;
              phase_d = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
              if (scl_i) begin
                scl_d   = 1'b0;
                phase_d = PH_SETUP;
              end
            end
            default: begin
              sda_d   = 1'b1;
              shift_d = 8'd0;
              bit_d   = 3'd7;
              phase_d = PH_RISE;
            end
          endcase
        end
        ST_STOP, ST_STOPFAIL: begin
          unique case (phase_q)
            PH_SETUP: begin
              sda_d   = 1'b0;
              phase_d = PH_RISE;
            end
            PH_RISE: begin
              scl_d   = 1'b1;
              phase_d = PH_HIGH;
            end
            default: begin
              if (scl_i) begin
                sda_d   = 1'b1;
                phase_d = PH_SETUP;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Prefetch the byte that the next request will see.
  assign rd_addr_o = widx_d[WrAw-1:0];

  always_comb begin
    res_o.scl_out    = scl_d;
    res_o.sda_out    = sda_d;
    res_o.read_valid = got_valid;
    res_o.read_data  = got_valid ? shift_in : 8'd0;
    if (state_d == ST_IDLE) begin
      res_o.status = STATUS_IDLE;
    end else if (state_d == ST_FAILED || state_d == ST_STOPFAIL) begin
      res_o.status = STATUS_FAILED;
    end else begin
      res_o.status = STATUS_BUSY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_SETUP;
      bit_q     <= 3'd0;
      widx_q    <= 8'd0;
      rcnt_q    <= 8'd0;
      shift_q   <= 8'd0;
      restart_q <= 1'b0;
      lcnt_q    <= 8'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      bit_q     <= bit_d;
      widx_q    <= widx_d;
      rcnt_q    <= rcnt_d;
      shift_q   <= shift_d;
      restart_q <= restart_d;
      lcnt_q    <= lcnt_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

endmodule

// ----- src/i2c_master_write_read_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_write_read_engine_unit
// I2C master write/read engine, one bus delay interval per tick request.
// ----------------------------------------------------------------------------
//   channel  | dir | payload                                         | port
//   ---------+-----+-------------------------------------------------+---------
//   request  | in  | mode, write_byte, sda_in, scl_in                | in_i
//   result   | out | scl_out, sda_out, read_data, read_valid, status | out_o
//   config   | in  | write_length, read_length, restart_position     | APB
//
// One request per cycle sustained while results are taken; each request is
// registered in the request stage, then its result in the output register.
// The write store is a 256 x 8 RAM read ahead of the request that
// uses it; a load landing on the prefetched entry is forwarded.
// Reset clears all control state; store contents stay unknown until loaded.
// A stalled result holds the output register; the request stage keeps one
// more request before ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_write_read_engine_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  i2cm_in_if.sink                    in_i,
  i2cm_out_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [i2cm_pkg::CfgAw-1:0] paddr,
  input  logic [i2cm_pkg::CfgDw-1:0] pwdata,
  output logic [i2cm_pkg::CfgDw-1:0] prdata,
  output logic                       pready
);
  import i2cm_pkg::*;

  cfg_t            cfg;
  mem_wr_t         mem_wr;
  result_t         res;
  result_t         out_q;
  logic [WrAw-1:0] rd_addr;
  logic [7:0]      ram_rdata;
  logic [7:0]      mem_data;
  logic            byp_q, byp_d;
  logic [7:0]      byp_data_q;

  logic            s1_valid_q, s1_valid_d;
  logic [1:0]      s1_mode_q;
  logic [7:0]      s1_byte_q;
  logic            s1_sda_q, s1_scl_q;
  logic            out_valid_q, out_valid_d;
  logic            in_fire, s1_fire, out_fire;

  assign s1_fire  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;

  assign s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_fire ? 1'b1 : (out_fire ? 1'b0 : out_valid_q);

  i2cm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  i2cm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_fire),
    .mode_i       (s1_mode_q),
    .write_byte_i (s1_byte_q),
    .sda_i        (s1_sda_q),
    .scl_i        (s1_scl_q),
    .cfg_i        (cfg),
    .mem_data_i   (mem_data),
    .rd_addr_o    (rd_addr),
    .wr_o         (mem_wr),
    .res_o        (res)
  );

  i2cm_ram #(
    .Width (8),
    .Depth (WriteDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_wr.we),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Forward a write that hits the entry read in the same cycle.
  assign byp_d    = mem_wr.we && (mem_wr.addr == rd_addr);
  assign mem_data = byp_q ? byp_data_q : ram_rdata;

  always_ff @(posedge clk_i) begin
    byp_data_q <= mem_wr.data;
    if (in_fire) begin
      s1_mode_q <= in_i.mode;
      s1_byte_q <= in_i.write_byte;
      s1_sda_q  <= in_i.sda_in;
      s1_scl_q  <= in_i.scl_in;
    end
    if (s1_fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      byp_q       <= byp_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.scl_out    = out_q.scl_out;
  assign out_o.sda_out    = out_q.sda_out;
  assign out_o.read_data  = out_q.read_data;
  assign out_o.read_valid = out_q.read_valid;
  assign out_o.status     = out_q.status;

  `ASSERT_CLK(a_stage_no_overwrite, in_fire && s1_valid_q |-> s1_fire,
              "request stage overwritten before it advanced")
  `ASSERT_CLK(a_result_registered, s1_fire |=> out_valid_q,
              "processed request left no result")
  `ASSERT_NEVER(a_read_while_not_busy, s1_fire && res.read_valid && res.status != STATUS_BUSY,
                "received byte reported outside a busy transaction")
  `ASSERT_NEVER(a_store_write_stray, mem_wr.we && !s1_fire,
                "store written without a request")

endmodule
